@@ hdl/lpc_pkg.sv @@
`timescale 1ns / 1ps
// Leader point clustering: shared types and constants.
// Used by leader_point_clustering and lpc_checker; no dependencies.
package lpc_pkg;

    localparam int COORD_W          = 16;
    localparam int SUM_W            = 24;
    localparam int COUNT_W          = 8;
    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_MAX_MEMBERS  = 255;

    localparam logic [COORD_W-1:0] MAX_DIST_RESET = 16'd288;  // 18.0 in 12.4

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               last_point;
    } lpc_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COUNT_W-1:0] member_count;
        logic               points_dropped;
        logic               last_center;
    } lpc_out_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [COUNT_W-1:0] count;
    } lpc_entry_t;

endpackage

@@ hdl/leader_point_clustering.sv @@
`timescale 1ns / 1ps
// Leader point clustering top level: sequencer, cluster store and shared multiplier.
// Depends on lpc_pkg.
//
// Usage
//   s_valid/s_ready/s_data carry one 2D point per transfer (12.4 unsigned).
//   m_valid/m_ready/m_data carry one cluster center per transfer.
//   cfg_wr_en/cfg_wr_data write the join radius; write it only while idle.
//   s_ready is high only while the block is idle; one point is worked at a time.
// Sequence
//   Each point scans every open cluster in turn (store read, then the distance
//   and range products), and each in-range cluster after the first also gets an
//   exact cross-multiplied nearest compare.
//   All of it runs through one 25x25 multiplier, one product per cycle. A new
//   point is not taken until the previous one is finished.
//   On a point marked last, every open cluster is sent: store read, 16-step
//   restoring divide for both means, then the output register, plus any stall.
// Reset
//   aresetn (synchronous, active low) empties the cluster table, clears the
//   drop flag and loads the radius with 18.0. The store itself is not cleared.
// Stall
//   A center waits in the output register while m_ready is low; the sequence
//   holds until the transfer completes.
module leader_point_clustering
    import lpc_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_MEMBERS  = DEF_MAX_MEMBERS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lpc_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lpc_out_t           m_data,
    input  logic               cfg_wr_en,
    input  logic [COORD_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int OPN_W = $clog2(MAX_CLUSTERS + 1);
    localparam logic [COUNT_W-1:0] MEMBER_CAP =
        COUNT_W'((MAX_MEMBERS > 255) ? 255 : MAX_MEMBERS);
    localparam logic [OPN_W-1:0] TABLE_FULL = OPN_W'(MAX_CLUSTERS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_M8, ST_M9, ST_M10, ST_M11, ST_M12,
        ST_DECIDE, ST_UPD, ST_FIN,
        ST_ERD, ST_EDIV0, ST_EDIV, ST_EOUT
    } state_t;

    // Cluster store: one write port, one registered read port.
    lpc_entry_t mem [MAX_CLUSTERS];
    lpc_entry_t rd_q;
    logic [IDX_W-1:0] mem_raddr, mem_waddr;
    logic             mem_we;
    lpc_entry_t       mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[mem_raddr];
    end

    // Control and datapath registers.
    state_t             state_reg, state_next;
    logic [OPN_W-1:0]   idx_reg, idx_next;
    logic [OPN_W-1:0]   open_reg, open_next;
    logic               drop_reg, drop_next;
    logic [COORD_W-1:0] maxd_reg;
    logic [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic               last_reg, last_next;
    logic [SUM_W-1:0]   ax_reg, ax_next, ay_reg, ay_next, lim_reg, lim_next;
    logic [47:0]        dx2_reg, dx2_next, dy2_reg, dy2_next, lim2_reg, lim2_next;
    logic [48:0]        d_reg, d_next;
    logic [15:0]        c2_reg, c2_next;
    logic [40:0]        plo_reg, plo_next, qlo_reg, qlo_next;
    logic [39:0]        phi_reg, phi_next, qhi_reg, qhi_next;
    logic               bvalid_reg, bvalid_next;
    logic [IDX_W-1:0]   bidx_reg, bidx_next;
    logic [48:0]        bd_reg, bd_next;
    logic [15:0]        bc2_reg, bc2_next;
    logic [SUM_W-1:0]   numx_reg, numx_next, numy_reg, numy_next;
    logic [COUNT_W-1:0] remx_reg, remx_next, remy_reg, remy_next;
    logic [3:0]         bit_reg, bit_next;
    logic               m_valid_reg, m_valid_next;
    lpc_out_t           m_data_reg, m_data_next;

    // Shared multiplier.
    logic [24:0] mul_a, mul_b;
    logic [49:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [SUM_W-1:0] dx, dy;
    logic [64:0]      lhs, rhs;
    logic [8:0]       trial_x, trial_y;
    logic             qx, qy;
    logic             scan_done;

    assign dx = (ax_reg >= rd_q.sum_x) ? ax_reg - rd_q.sum_x : rd_q.sum_x - ax_reg;
    assign dy = (ay_reg >= rd_q.sum_y) ? ay_reg - rd_q.sum_y : rd_q.sum_y - ay_reg;
    assign lhs = {phi_reg, 25'b0} + 65'(plo_reg);
    assign rhs = {qhi_reg, 25'b0} + 65'(qlo_reg);
    assign trial_x = {remx_reg, numx_reg[15]};
    assign trial_y = {remy_reg, numy_reg[15]};
    assign qx = (trial_x >= {1'b0, rd_q.count});
    assign qy = (trial_y >= {1'b0, rd_q.count});
    assign scan_done = ((idx_reg + OPN_W'(1)) == open_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        open_next    = open_reg;
        drop_next    = drop_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        last_next    = last_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        lim_next     = lim_reg;
        dx2_next     = dx2_reg;
        dy2_next     = dy2_reg;
        lim2_next    = lim2_reg;
        d_next       = d_reg;
        c2_next      = c2_reg;
        plo_next     = plo_reg;
        phi_next     = phi_reg;
        qlo_next     = qlo_reg;
        qhi_next     = qhi_reg;
        bvalid_next  = bvalid_reg;
        bidx_next    = bidx_reg;
        bd_next      = bd_reg;
        bc2_next     = bc2_reg;
        numx_next    = numx_reg;
        numy_next    = numy_reg;
        remx_next    = remx_reg;
        remy_next    = remy_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mul_a        = '0;
        mul_b        = '0;
        mem_raddr    = idx_reg[IDX_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = open_reg[IDX_W-1:0];
        mem_wdata    = '{sum_x: SUM_W'(px_reg), sum_y: SUM_W'(py_reg), count: COUNT_W'(1)};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    px_next     = s_data.point_x;
                    py_next     = s_data.point_y;
                    last_next   = s_data.last_point;
                    idx_next    = '0;
                    bvalid_next = 1'b0;
                    state_next  = (open_reg == '0) ? ST_DECIDE : ST_RD;
                end
            end
            ST_RD: state_next = ST_M1;
            ST_M1: begin
                mul_a      = 25'(rd_q.count);
                mul_b      = 25'(px_reg);
                ax_next    = mul_p[SUM_W-1:0];
                state_next = ST_M2;
            end
            ST_M2: begin
                mul_a      = 25'(rd_q.count);
                mul_b      = 25'(py_reg);
                ay_next    = mul_p[SUM_W-1:0];
                state_next = ST_M3;
            end
            ST_M3: begin
                mul_a      = 25'(rd_q.count);
                mul_b      = 25'(maxd_reg);
                lim_next   = mul_p[SUM_W-1:0];
                state_next = ST_M4;
            end
            ST_M4: begin
                mul_a      = 25'(dx);
                mul_b      = 25'(dx);
                dx2_next   = mul_p[47:0];
                state_next = ST_M5;
            end
            ST_M5: begin
                mul_a      = 25'(dy);
                mul_b      = 25'(dy);
                dy2_next   = mul_p[47:0];
                state_next = ST_M6;
            end
            ST_M6: begin
                mul_a      = 25'(lim_reg);
                mul_b      = 25'(lim_reg);
                lim2_next  = mul_p[47:0];
                d_next     = 49'(dx2_reg) + 49'(dy2_reg);
                state_next = ST_M7;
            end
            ST_M7: begin
                mul_a   = 25'(rd_q.count);
                mul_b   = 25'(rd_q.count);
                c2_next = mul_p[15:0];
                if (d_reg > 49'(lim2_reg) || !bvalid_reg) begin
                    // out of range: skip; first in-range cluster: take it
                    if (d_reg <= 49'(lim2_reg)) begin
                        bvalid_next = 1'b1;
                        bidx_next   = idx_reg[IDX_W-1:0];
                        bd_next     = d_reg;
                        bc2_next    = mul_p[15:0];
                    end
                    if (scan_done) begin
                        state_next = ST_DECIDE;
                    end else begin
                        idx_next   = idx_reg + OPN_W'(1);
                        state_next = ST_RD;
                    end
                end else begin
                    state_next = ST_M8;
                end
            end
            ST_M8: begin
                mul_a      = d_reg[24:0];
                mul_b      = 25'(bc2_reg);
                plo_next   = mul_p[40:0];
                state_next = ST_M9;
            end
            ST_M9: begin
                mul_a      = 25'(d_reg[48:25]);
                mul_b      = 25'(bc2_reg);
                phi_next   = mul_p[39:0];
                state_next = ST_M10;
            end
            ST_M10: begin
                mul_a      = bd_reg[24:0];
                mul_b      = 25'(c2_reg);
                qlo_next   = mul_p[40:0];
                state_next = ST_M11;
            end
            ST_M11: begin
                mul_a      = 25'(bd_reg[48:25]);
                mul_b      = 25'(c2_reg);
                qhi_next   = mul_p[39:0];
                state_next = ST_M12;
            end
            ST_M12: begin
                // equal distance goes to the later cluster
                if (lhs <= rhs) begin
                    bidx_next = idx_reg[IDX_W-1:0];
                    bd_next   = d_reg;
                    bc2_next  = c2_reg;
                end
                if (scan_done) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + OPN_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_DECIDE: begin
                mem_raddr = bidx_reg;
                if (bvalid_reg) begin
                    state_next = ST_UPD;
                end else if (open_reg < TABLE_FULL) begin
                    mem_we     = 1'b1;
                    open_next  = open_reg + OPN_W'(1);
                    state_next = ST_FIN;
                end else begin
                    drop_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_UPD: begin
                mem_waddr = bidx_reg;
                mem_wdata = '{sum_x: rd_q.sum_x + SUM_W'(px_reg),
                              sum_y: rd_q.sum_y + SUM_W'(py_reg),
                              count: rd_q.count + COUNT_W'(1)};
                if (rd_q.count >= MEMBER_CAP) begin
                    drop_next = 1'b1;
                end else begin
                    mem_we = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                idx_next = '0;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (open_reg == '0) begin
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_ERD;
                end
            end
            ST_ERD: state_next = ST_EDIV0;
            ST_EDIV0: begin
                numx_next  = rd_q.sum_x + SUM_W'(rd_q.count >> 1);
                numy_next  = rd_q.sum_y + SUM_W'(rd_q.count >> 1);
                remx_next  = numx_next[23:16];
                remy_next  = numy_next[23:16];
                bit_next   = '0;
                state_next = ST_EDIV;
            end
            ST_EDIV: begin
                // one quotient bit per cycle for both means
                remx_next = qx ? COUNT_W'(trial_x - {1'b0, rd_q.count}) : trial_x[7:0];
                remy_next = qy ? COUNT_W'(trial_y - {1'b0, rd_q.count}) : trial_y[7:0];
                numx_next = {numx_reg[SUM_W-1:16], numx_reg[14:0], qx};
                numy_next = {numy_reg[SUM_W-1:16], numy_reg[14:0], qy};
                bit_next  = bit_reg + 4'd1;
                if (bit_reg == 4'd15) begin
                    m_data_next.center_x       = numx_next[15:0];
                    m_data_next.center_y       = numy_next[15:0];
                    m_data_next.member_count   = rd_q.count;
                    m_data_next.points_dropped = drop_reg;
                    m_data_next.last_center    = scan_done;
                    m_valid_next               = 1'b1;
                    state_next                 = ST_EOUT;
                end
            end
            ST_EOUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (scan_done) begin
                        open_next  = '0;
                        drop_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + OPN_W'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            open_reg    <= '0;
            drop_reg    <= 1'b0;
            bvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            maxd_reg    <= MAX_DIST_RESET;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            open_reg    <= open_next;
            drop_reg    <= drop_next;
            bvalid_reg  <= bvalid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                maxd_reg <= cfg_wr_data;
            end
        end
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        lim_reg    <= lim_next;
        dx2_reg    <= dx2_next;
        dy2_reg    <= dy2_next;
        lim2_reg   <= lim2_next;
        d_reg      <= d_next;
        c2_reg     <= c2_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        qlo_reg    <= qlo_next;
        qhi_reg    <= qhi_next;
        bidx_reg   <= bidx_next;
        bd_reg     <= bd_next;
        bc2_reg    <= bc2_next;
        numx_reg   <= numx_next;
        numy_reg   <= numy_next;
        remx_reg   <= remx_next;
        remy_reg   <= remy_next;
        bit_reg    <= bit_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ hdl/lpc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for leader_point_clustering, attached by bind.
// Depends on lpc_pkg.
module lpc_port_checks
    import lpc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input lpc_in_t            s_data,
    input logic               m_valid,
    input logic               m_ready,
    input lpc_out_t           m_data
);

    // hold a stalled center
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("center changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a center is pending");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.member_count != '0)
        else $error("center with no members");

    a_input_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_point |=> !m_valid)
        else $error("center sent for a point not marked last");

endmodule

bind leader_point_clustering lpc_port_checks u_lpc_port_checks (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_data     (s_data),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data     (m_data)
);
